// ===== rtl/hc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hc_pkg;

	// alphabet size and fixed field widths
	localparam int MODULUS  = 26;
	localparam int MAX_N    = 3;
	localparam int LETTER_W = 5;
	localparam int KEY_W    = 45;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef letter_t [MAX_N-1:0] vec_t;
	typedef vec_t [MAX_N-1:0]    mat_t;

	// one block on its way down the cell row
	typedef struct packed {
		logic dec;
		logic err;
		vec_t letter;
		vec_t acc;
	} item_t;

	// key state handed from the derivation unit to the datapath
	typedef struct packed {
		mat_t key_m;
		mat_t inv_m;
		logic invertible;
		logic busy;
	} key_state_t;

	// x mod 26 for x below 2048: reciprocal estimate, then one correction
	function automatic letter_t mod26_f(input logic [10:0] x);
		logic [17:0] prod;
		logic [6:0]  q;
		logic [10:0] rem;
		prod = 18'(x) * 18'd78;
		q    = prod[17:11];
		rem  = x - (11'(q) * 11'(MODULUS));
		if (rem >= 11'(MODULUS)) begin
			rem = rem - 11'(MODULUS);
		end
		return rem[LETTER_W-1:0];
	endfunction

	// fold a raw five-bit value into 0..25
	function automatic letter_t reduce_f(input letter_t x);
		return (x >= letter_t'(MODULUS)) ? letter_t'(x - letter_t'(MODULUS)) : x;
	endfunction

	// multiplicative inverse mod 26, zero for non-units
	function automatic letter_t unit_inv_f(input letter_t d);
		letter_t r;
		unique case (d)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// block channel: mode and three letters
interface hc_blk_if;
	logic              valid;
	logic              ready;
	logic              mode;
	hc_pkg::letter_t   letter_0;
	hc_pkg::letter_t   letter_1;
	hc_pkg::letter_t   letter_2;

	modport source (output valid, mode, letter_0, letter_1, letter_2, input ready);
	modport sink   (input valid, mode, letter_0, letter_1, letter_2, output ready);
endinterface

// result channel: three letters and status
interface hc_res_if;
	logic              valid;
	logic              ready;
	hc_pkg::letter_t   out_letter_0;
	hc_pkg::letter_t   out_letter_1;
	hc_pkg::letter_t   out_letter_2;
	logic              status;

	modport source (output valid, out_letter_0, out_letter_1, out_letter_2, status,
		input ready);
	modport sink   (input valid, out_letter_0, out_letter_1, out_letter_2, status,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/hc_key_derive.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hc_key_derive #(
	parameter int BLOCK_SIZE = 3
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [hc_pkg::KEY_W-1:0] cfg_data,
	output hc_pkg::key_state_t          key_state
);

	localparam int NB = (BLOCK_SIZE < 2) ? 2 : ((BLOCK_SIZE > 3) ? 3 : BLOCK_SIZE);

	hc_pkg::mat_t    key_m_q;
	hc_pkg::mat_t    cof_c;
	hc_pkg::mat_t    cof_s2;
	hc_pkg::mat_t    cof_s3;
	hc_pkg::letter_t det_c;
	hc_pkg::letter_t dinv_s3;
	hc_pkg::mat_t    inv_q;
	logic            invertible_q;
	logic            v_s1;
	logic            v_s2;
	logic            v_s3;

	// key register: entries folded into 0..25, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < hc_pkg::MAX_N; r++) begin
				for (int c = 0; c < hc_pkg::MAX_N; c++) begin
					key_m_q[r][c] <= (r == c && r < NB) ? 5'd1 : 5'd0;
				end
			end
		end else if (cfg_we) begin
			for (int r = 0; r < hc_pkg::MAX_N; r++) begin
				for (int c = 0; c < hc_pkg::MAX_N; c++) begin
					if (r < NB && c < NB) begin
						key_m_q[r][c] <= hc_pkg::reduce_f(
							cfg_data[hc_pkg::LETTER_W*(r*NB+c) +: hc_pkg::LETTER_W]);
					end else begin
						key_m_q[r][c] <= 5'd0;
					end
				end
			end
		end
	end

	// cofactors of the key
	generate
		if (NB == 2) begin : g_cof2
			always_comb begin
				cof_c = '0;
				cof_c[0][0] = key_m_q[1][1];
				cof_c[0][1] = hc_pkg::mod26_f(11'(hc_pkg::MODULUS) - 11'(key_m_q[1][0]));
				cof_c[1][0] = hc_pkg::mod26_f(11'(hc_pkg::MODULUS) - 11'(key_m_q[0][1]));
				cof_c[1][1] = key_m_q[0][0];
			end
		end else begin : g_cof3
			for (genvar r = 0; r < 3; r++) begin : g_r
				for (genvar c = 0; c < 3; c++) begin : g_c
					localparam int R1 = (r + 1) % 3;
					localparam int R2 = (r + 2) % 3;
					localparam int C1 = (c + 1) % 3;
					localparam int C2 = (c + 2) % 3;
					logic [9:0] pa;
					logic [9:0] pb;
					assign pa = 10'(key_m_q[R1][C1]) * 10'(key_m_q[R2][C2]);
					assign pb = 10'(key_m_q[R1][C2]) * 10'(key_m_q[R2][C1]);
					assign cof_c[r][c] = hc_pkg::mod26_f(11'(pa) + 11'd676 - 11'(pb));
				end
			end
		end
	endgenerate

	// determinant along the first row, then its inverse
	always_comb begin
		logic [10:0] sum;
		sum = '0;
		for (int c = 0; c < hc_pkg::MAX_N; c++) begin
			sum = sum + 11'(10'(key_m_q[0][c]) * 10'(cof_s2[0][c]));
		end
		det_c = hc_pkg::mod26_f(sum);
	end

	// derivation pipeline
	always_ff @(posedge clk) begin
		cof_s2  <= cof_c;
		cof_s3  <= cof_s2;
		dinv_s3 <= hc_pkg::unit_inv_f(det_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cfg_we;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// inverse key: transposed cofactors times inverse determinant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invertible_q <= 1'b1;
			for (int r = 0; r < hc_pkg::MAX_N; r++) begin
				for (int c = 0; c < hc_pkg::MAX_N; c++) begin
					inv_q[r][c] <= (r == c && r < NB) ? 5'd1 : 5'd0;
				end
			end
		end else if (v_s3) begin
			invertible_q <= (dinv_s3 != 5'd0);
			for (int r = 0; r < hc_pkg::MAX_N; r++) begin
				for (int c = 0; c < hc_pkg::MAX_N; c++) begin
					inv_q[r][c] <= hc_pkg::mod26_f(11'(10'(cof_s3[c][r]) * 10'(dinv_s3)));
				end
			end
		end
	end

	assign key_state.key_m      = key_m_q;
	assign key_state.inv_m      = inv_q;
	assign key_state.invertible = invertible_q;
	assign key_state.busy       = v_s1 | v_s2 | v_s3;

endmodule

`default_nettype wire

// ===== rtl/hc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hc_cell #(
	parameter int COL = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire hc_pkg::item_t up_data,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output hc_pkg::item_t      dn_data,
	input  wire hc_pkg::vec_t  enc_col,
	input  wire hc_pkg::vec_t  dec_col
);

	logic          valid_q;
	hc_pkg::item_t data_q;
	hc_pkg::item_t next_c;

	// take a new item when empty or when the neighbor takes ours
	assign up_ready = !valid_q || dn_ready;

	// add this column's share to every row sum
	always_comb begin
		hc_pkg::vec_t sel;
		sel    = up_data.dec ? dec_col : enc_col;
		next_c = up_data;
		for (int r = 0; r < hc_pkg::MAX_N; r++) begin
			next_c.acc[r] = hc_pkg::mod26_f(11'(up_data.acc[r]) +
				11'(10'(sel[r]) * 10'(up_data.letter[COL])));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= next_c;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

`default_nettype wire

// ===== rtl/hill_cipher_block.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Hill cipher engine, one block of BLOCK_SIZE letters (a=0 .. z=25) per transfer.
// blk carries mode (0 encrypt, 1 decrypt) and letter_0..letter_2; res carries
// out_letter_0..out_letter_2 and status (1: decrypt with a key that has no
// inverse mod 26, letters then zero). Unused letter fields are ignored / zero.
// Datapath is a row of NB cells (BLOCK_SIZE clamped to 2..3), one per key column;
// each cell adds its column's products to the row sums and hands the block on;
// one block is taken every cycle while res keeps up and no key is being derived.
// The last cell's register drives res; if res stalls, the row fills up behind it
// and blk.ready drops only once every cell holds a block.
// A write on cfg_we loads the key; the inverse is derived by a three-stage
// pipeline and blk.ready is low while that derivation runs.
// Reset loads the identity key (and identity inverse), so both modes pass the
// letters through until a key is written.
module hill_cipher_block #(
	parameter int BLOCK_SIZE = 3
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [hc_pkg::KEY_W-1:0] cfg_data,
	hc_blk_if.sink                        blk,
	hc_res_if.source                      res
);

	localparam int NB = (BLOCK_SIZE < 2) ? 2 : ((BLOCK_SIZE > 3) ? 3 : BLOCK_SIZE);

	hc_pkg::key_state_t key_state;
	logic               link_valid [NB+1];
	logic               link_ready [NB+1];
	hc_pkg::item_t      link_data  [NB+1];
	hc_pkg::item_t      last_item;

	// key register and inverse derivation
	hc_key_derive #(
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_derive (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.key_state (key_state)
	);

	// entry: fold letters, flag decrypt with a singular key
	assign link_valid[0] = blk.valid && !key_state.busy;
	assign blk.ready     = link_ready[0] && !key_state.busy;

	always_comb begin
		link_data[0]           = '0;
		link_data[0].dec       = blk.mode;
		link_data[0].err       = blk.mode && !key_state.invertible;
		link_data[0].letter[0] = hc_pkg::reduce_f(blk.letter_0);
		link_data[0].letter[1] = hc_pkg::reduce_f(blk.letter_1);
		link_data[0].letter[2] = (NB > 2) ? hc_pkg::reduce_f(blk.letter_2) : 5'd0;
	end

	// row of column cells
	generate
		for (genvar c = 0; c < NB; c++) begin : g_cell
			hc_pkg::vec_t enc_col;
			hc_pkg::vec_t dec_col;
			for (genvar r = 0; r < hc_pkg::MAX_N; r++) begin : g_tap
				assign enc_col[r] = key_state.key_m[r][c];
				assign dec_col[r] = key_state.inv_m[r][c];
			end
			hc_cell #(
				.COL (c)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid (link_valid[c]),
				.up_ready (link_ready[c]),
				.up_data  (link_data[c]),
				.dn_valid (link_valid[c+1]),
				.dn_ready (link_ready[c+1]),
				.dn_data  (link_data[c+1]),
				.enc_col  (enc_col),
				.dec_col  (dec_col)
			);
		end
	endgenerate

	// result side, letters cleared on error
	assign last_item      = link_data[NB];
	assign res.valid      = link_valid[NB];
	assign link_ready[NB] = res.ready;
	assign res.status     = last_item.err;
	assign res.out_letter_0 = last_item.err ? 5'd0 : last_item.acc[0];
	assign res.out_letter_1 = last_item.err ? 5'd0 : last_item.acc[1];
	assign res.out_letter_2 = last_item.err ? 5'd0 : last_item.acc[2];

	// no block enters while the inverse is being derived
	assert property (@(posedge clk) disable iff (!arst_n)
		key_state.busy |-> !blk.ready)
		else $error("block taken during key derivation");

	// error results carry zero letters
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status) |->
		(res.out_letter_0 == 5'd0 && res.out_letter_1 == 5'd0 && res.out_letter_2 == 5'd0))
		else $error("error result with nonzero letters");

	// error only for decrypt with a singular key
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status) |-> (last_item.dec && !key_state.invertible))
		else $error("error status without singular decrypt key");

	// encrypt never reports an error
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !last_item.dec) |-> !res.status)
		else $error("error status on encrypt");

endmodule

`default_nettype wire
